/* hdl/ethernet_ip_header_parser_core_macros.svh */
// ----------------------------------------------------------------------------
// ethernet ip header parser core assertion macros
// implication checks shared by the parser rtl
// ----------------------------------------------------------------------------
`ifndef ETHERNET_IP_HEADER_PARSER_CORE_MACROS_SVH
`define ETHERNET_IP_HEADER_PARSER_CORE_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define EIPHP_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("parser check failed in same cycle");

// consequent must hold in the cycle after the antecedent
`define EIPHP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("parser check failed one cycle later");

`endif

/* hdl/eiphp_pkg.sv */
// ----------------------------------------------------------------------------
// eiphp_pkg
// types and constants of the ethernet / ip header parser
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package eiphp_pkg;

    localparam int OFFSET_BITS = 16;
    localparam int LEN_BITS    = OFFSET_BITS + 1;

    localparam logic [15:0] ETYPE_VLAN    = 16'h8100;
    localparam logic [15:0] ETYPE_ARP     = 16'h0806;
    localparam logic [15:0] ETYPE_IPV4    = 16'h0800;
    localparam logic [15:0] ETYPE_IPV6    = 16'h86DD;
    localparam logic [7:0]  PROTO_ICMP    = 8'd1;
    localparam logic [7:0]  PROTO_UDP     = 8'd17;
    localparam logic [7:0]  PROTO_TCP     = 8'd6;
    localparam logic [15:0] ARP_HTYPE_ETH = 16'd1;
    localparam logic [7:0]  MAC_ADDR_LEN  = 8'd6;
    localparam logic [7:0]  IPV4_ALEN     = 8'd4;

    localparam logic [7:0] ETH_HDR_LEN   = 8'd14;
    localparam logic [7:0] VLAN_HDR_END  = 8'd18;
    localparam logic [7:0] IPV6_HDR_LEN  = 8'd40;
    localparam int         ARP_LEN       = 28;
    localparam int         IPV4_MIN_LEN  = 20;
    localparam int         IPV6_LEN      = 40;
    localparam int         SHORT_L4_LEN  = 8;
    localparam int         TCP_LEN       = 20;

    typedef enum logic [3:0] {
        ST_OK          = 4'd0,
        ST_L2_SHORT    = 4'd1,
        ST_L3_SHORT    = 4'd2,
        ST_L4_SHORT    = 4'd3,
        ST_L3_UNSUP    = 4'd4,
        ST_L4_UNSUP    = 4'd5,
        ST_ARP_HRD_BAD = 4'd6,
        ST_ARP_PRO_BAD = 4'd7,
        ST_ARP_HLN_BAD = 4'd8,
        ST_ARP_PLN_BAD = 4'd9
    } status_t;

    typedef enum logic [2:0] {
        PH_ETH   = 3'd0,
        PH_VLAN  = 3'd1,
        PH_ARP   = 3'd2,
        PH_IPV4  = 3'd3,
        PH_IPV6  = 3'd4,
        PH_OTHER = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        NK_NONE = 2'd0,
        NK_ARP  = 2'd1,
        NK_IPV4 = 2'd2,
        NK_IPV6 = 2'd3
    } net_kind_t;

    typedef enum logic [1:0] {
        TK_NONE = 2'd0,
        TK_ICMP = 2'd1,
        TK_UDP  = 2'd2,
        TK_TCP  = 2'd3
    } trans_kind_t;

    // first member sits in the top bits, so status lands at bit 0
    typedef struct packed {
        logic [6:0]  pad;
        logic [15:0] dest_port;
        logic [15:0] source_port;
        logic [63:0] dest_addr_low;
        logic [63:0] dest_addr_high;
        logic [63:0] source_addr_low;
        logic [63:0] source_addr_high;
        trans_kind_t transport_kind;
        net_kind_t   network_kind;
        logic        vlan_tagged;
        status_t     parse_status;
    } result_t;

    localparam int RESULT_BITS = $bits(result_t);

    function automatic phase_t phase_for_type(input logic [15:0] ethertype);
        phase_t ph;
        if (ethertype == ETYPE_ARP) begin
            ph = PH_ARP;
        end else if (ethertype == ETYPE_IPV4) begin
            ph = PH_IPV4;
        end else if (ethertype == ETYPE_IPV6) begin
            ph = PH_IPV6;
        end else begin
            ph = PH_OTHER;
        end
        return ph;
    endfunction

endpackage

`default_nettype wire

/* hdl/ethernet_ip_header_parser_core.sv */
// ----------------------------------------------------------------------------
// ethernet_ip_header_parser_core
// byte-wide parser for ethernet, one vlan tag, arp, ipv4/ipv6 and icmp/udp/tcp
// ----------------------------------------------------------------------------
// Frames enter one byte per cycle on the slave stream, tlast on the final byte,
// and the core takes a byte in every cycle that it does not stall. Each byte
// passes an input register and then updates the offset and capture registers;
// on the final byte the status, layer kinds, addresses and ports go to the
// output register. Other bytes produce no output transaction.
// The input side stalls only when a final byte meets an output register that
// still holds an untaken result. On any error all fields but the status are
// zero. The byte offset saturates, so very long frames pass every length check.
`timescale 1ns / 1ps
`default_nettype none

`include "ethernet_ip_header_parser_core_macros.svh"

module ethernet_ip_header_parser_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [7:0]                    s_axis_tdata,  // frame_byte[7:0]
    input  wire logic                          s_axis_tlast,  // frame_last
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // parse_status[3:0], vlan_tagged[4], network_kind[6:5], transport_kind[8:7],
    // source_addr_high[72:9], source_addr_low[136:73], dest_addr_high[200:137],
    // dest_addr_low[264:201], source_port[280:265], dest_port[296:281], zeros above
    output logic [eiphp_pkg::RESULT_BITS-1:0]  m_axis_tdata
);

    import eiphp_pkg::*;

    localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;

    // input register
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // frame state
    logic [OFFSET_BITS-1:0] offset_reg, offset_next;
    phase_t                 phase_reg, phase_next;
    logic [7:0]             net_start_reg, net_start_next;
    logic [7:0]             trans_start_reg, trans_start_next;
    logic [15:0]            type_word_reg, type_word_next;
    logic [7:0]             ip_proto_reg, ip_proto_next;
    logic [7:0]             arp_hdr_reg [8];
    logic [7:0]             arp_hdr_next [8];
    logic [63:0]            src_hi_reg, src_hi_next;
    logic [63:0]            src_lo_reg, src_lo_next;
    logic [63:0]            dst_hi_reg, dst_hi_next;
    logic [63:0]            dst_lo_reg, dst_lo_next;
    logic [15:0]            port_reg [2];
    logic [15:0]            port_next [2];
    status_t                early_err_reg, early_err_next;

    // output register
    logic    m_valid_reg, m_valid_next;
    result_t m_data_reg;
    result_t result;

    logic stall;
    logic proc;
    logic load;

    assign stall         = in_valid_reg && in_last_reg && m_valid_reg && !m_axis_tready;
    assign proc          = in_valid_reg && !stall;
    assign load          = proc && in_last_reg;
    assign s_axis_tready = !in_valid_reg || !stall;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    always_comb begin
        logic [OFFSET_BITS-1:0] off;
        logic [OFFSET_BITS-1:0] rel;
        logic [LEN_BITS-1:0]    off_ext;
        logic [LEN_BITS-1:0]    ts_ext;
        logic [LEN_BITS-1:0]    port_diff;
        logic [LEN_BITS-1:0]    len;
        logic [LEN_BITS-1:0]    need;
        logic [7:0]             b;
        logic                   ip;
        status_t                st;
        trans_kind_t            tk;

        off = offset_reg;
        b   = in_byte_reg;

        phase_next       = phase_reg;
        net_start_next   = net_start_reg;
        trans_start_next = trans_start_reg;
        type_word_next   = type_word_reg;
        ip_proto_next    = ip_proto_reg;
        arp_hdr_next     = arp_hdr_reg;
        src_hi_next      = src_hi_reg;
        src_lo_next      = src_lo_reg;
        dst_hi_next      = dst_hi_reg;
        dst_lo_next      = dst_lo_reg;
        port_next        = port_reg;
        early_err_next   = early_err_reg;

        rel = off - OFFSET_BITS'(net_start_reg);

        if (off == OFFSET_BITS'(12) || off == OFFSET_BITS'(13) ||
            (phase_reg == PH_VLAN && (off == OFFSET_BITS'(16) || off == OFFSET_BITS'(17)))) begin
            type_word_next = {type_word_reg[7:0], b};
        end

        if (phase_reg == PH_ETH && off == OFFSET_BITS'(13)) begin
            if (type_word_next == ETYPE_VLAN) begin
                phase_next     = PH_VLAN;
                net_start_next = VLAN_HDR_END;
            end else begin
                phase_next     = phase_for_type(type_word_next);
                net_start_next = ETH_HDR_LEN;
                if (phase_next == PH_IPV6) begin
                    trans_start_next = ETH_HDR_LEN + IPV6_HDR_LEN;
                end
            end
        end else if (phase_reg == PH_VLAN) begin
            if (off == OFFSET_BITS'(17)) begin
                phase_next     = phase_for_type(type_word_next);
                net_start_next = VLAN_HDR_END;
                if (phase_next == PH_IPV6) begin
                    trans_start_next = VLAN_HDR_END + IPV6_HDR_LEN;
                end
            end
        end else if (off >= OFFSET_BITS'(net_start_reg)) begin
            if (phase_reg == PH_ARP) begin
                if (rel < OFFSET_BITS'(8)) begin
                    arp_hdr_next[rel[2:0]] = b;
                end else if (rel >= OFFSET_BITS'(14) && rel < OFFSET_BITS'(18)) begin
                    src_lo_next = {src_lo_reg[55:0], b};
                end else if (rel >= OFFSET_BITS'(24) && rel < OFFSET_BITS'(28)) begin
                    dst_lo_next = {dst_lo_reg[55:0], b};
                end
            end else if (phase_reg == PH_IPV4) begin
                if (rel == '0) begin
                    trans_start_next = net_start_reg + {2'b00, b[3:0], 2'b00};
                    early_err_next   = (b[3:0] < 4'd5) ? ST_L3_SHORT : ST_OK;
                end
                if (rel == OFFSET_BITS'(9)) begin
                    ip_proto_next = b;
                end
                if (rel >= OFFSET_BITS'(12) && rel < OFFSET_BITS'(16)) begin
                    src_lo_next = {src_lo_reg[55:0], b};
                end
                if (rel >= OFFSET_BITS'(16) && rel < OFFSET_BITS'(20)) begin
                    dst_lo_next = {dst_lo_reg[55:0], b};
                end
            end else if (phase_reg == PH_IPV6) begin
                if (rel == OFFSET_BITS'(6)) begin
                    ip_proto_next = b;
                end
                if (rel >= OFFSET_BITS'(8) && rel < OFFSET_BITS'(24)) begin
                    src_hi_next = {src_hi_reg[55:0], src_lo_reg[63:56]};
                    src_lo_next = {src_lo_reg[55:0], b};
                end
                if (rel >= OFFSET_BITS'(24) && rel < OFFSET_BITS'(40)) begin
                    dst_hi_next = {dst_hi_reg[55:0], dst_lo_reg[63:56]};
                    dst_lo_next = {dst_lo_reg[55:0], b};
                end
            end
        end

        // l4 ports: first four bytes after the ip header, past its first byte
        off_ext   = {1'b0, off};
        ts_ext    = LEN_BITS'(trans_start_next);
        port_diff = off_ext - ts_ext;
        if ((phase_reg == PH_IPV4 || phase_reg == PH_IPV6) &&
            off >= OFFSET_BITS'(net_start_reg) && rel != '0 &&
            off_ext >= ts_ext && off_ext < ts_ext + LEN_BITS'(4)) begin
            port_next[port_diff[1]] = {port_reg[port_diff[1]][7:0], b};
        end

        // end of frame evaluation on the updated state
        len  = off_ext + LEN_BITS'(1);
        need = '0;
        st   = ST_OK;
        tk   = TK_NONE;
        ip   = 1'b0;
        unique case (phase_next)
            PH_ETH, PH_VLAN: begin
                st = ST_L2_SHORT;
            end
            PH_OTHER: begin
                st = ST_L3_UNSUP;
            end
            PH_ARP: begin
                if (len < LEN_BITS'(net_start_next) + LEN_BITS'(ARP_LEN)) begin
                    st = ST_L2_SHORT;
                end else if ({arp_hdr_next[0], arp_hdr_next[1]} != ARP_HTYPE_ETH) begin
                    st = ST_ARP_HRD_BAD;
                end else if (arp_hdr_next[4] != MAC_ADDR_LEN) begin
                    st = ST_ARP_HLN_BAD;
                end else if ({arp_hdr_next[2], arp_hdr_next[3]} != ETYPE_IPV4) begin
                    st = ST_ARP_PRO_BAD;
                end else if (arp_hdr_next[5] != IPV4_ALEN) begin
                    st = ST_ARP_PLN_BAD;
                end
            end
            PH_IPV4: begin
                ip = 1'b1;
                if (len < LEN_BITS'(net_start_next) + LEN_BITS'(IPV4_MIN_LEN) ||
                    early_err_next != ST_OK) begin
                    st = ST_L3_SHORT;
                end
            end
            PH_IPV6: begin
                ip = 1'b1;
                if (len < LEN_BITS'(net_start_next) + LEN_BITS'(IPV6_LEN)) begin
                    st = ST_L3_SHORT;
                end
            end
            default: begin
                st = ST_L3_UNSUP;
            end
        endcase

        if (ip && st == ST_OK) begin
            if (ip_proto_next == PROTO_ICMP) begin
                tk   = TK_ICMP;
                need = LEN_BITS'(SHORT_L4_LEN);
            end else if (ip_proto_next == PROTO_UDP) begin
                tk   = TK_UDP;
                need = LEN_BITS'(SHORT_L4_LEN);
            end else if (ip_proto_next == PROTO_TCP) begin
                tk   = TK_TCP;
                need = LEN_BITS'(TCP_LEN);
            end else begin
                st = ST_L4_UNSUP;
            end
            if (st == ST_OK && len < LEN_BITS'(trans_start_next) + need) begin
                st = ST_L4_SHORT;
            end
        end

        result              = '0;
        result.parse_status = st;
        if (st == ST_OK) begin
            result.vlan_tagged    = (net_start_next == VLAN_HDR_END);
            result.transport_kind = tk;
            if (phase_next == PH_ARP) begin
                result.network_kind = NK_ARP;
            end else if (phase_next == PH_IPV4) begin
                result.network_kind = NK_IPV4;
            end else begin
                result.network_kind = NK_IPV6;
            end
            if (phase_next == PH_IPV6) begin
                result.source_addr_high = src_hi_next;
                result.source_addr_low  = src_lo_next;
                result.dest_addr_high   = dst_hi_next;
                result.dest_addr_low    = dst_lo_next;
            end else begin
                result.source_addr_low = {32'd0, src_lo_next[31:0]};
                result.dest_addr_low   = {32'd0, dst_lo_next[31:0]};
            end
            if (tk == TK_UDP || tk == TK_TCP) begin
                result.source_port = port_next[0];
                result.dest_port   = port_next[1];
            end
        end

        // offset update; a final byte clears the frame state
        if (off < OFFSET_MAX) begin
            offset_next = off + OFFSET_BITS'(1);
        end else begin
            offset_next = off;
        end
        if (in_last_reg) begin
            offset_next      = '0;
            phase_next       = PH_ETH;
            net_start_next   = ETH_HDR_LEN;
            trans_start_next = '0;
            type_word_next   = '0;
            ip_proto_next    = '0;
            for (int i = 0; i < 8; i++) begin
                arp_hdr_next[i] = '0;
            end
            src_hi_next    = '0;
            src_lo_next    = '0;
            dst_hi_next    = '0;
            dst_lo_next    = '0;
            port_next[0]   = '0;
            port_next[1]   = '0;
            early_err_next = ST_OK;
        end
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_axis_tvalid && s_axis_tready) begin
            in_valid_next = 1'b1;
        end else if (proc) begin
            in_valid_next = 1'b0;
        end

        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
            offset_reg      <= '0;
            phase_reg       <= PH_ETH;
            net_start_reg   <= ETH_HDR_LEN;
            trans_start_reg <= '0;
            type_word_reg   <= '0;
            ip_proto_reg    <= '0;
            for (int i = 0; i < 8; i++) begin
                arp_hdr_reg[i] <= '0;
            end
            src_hi_reg    <= '0;
            src_lo_reg    <= '0;
            dst_hi_reg    <= '0;
            dst_lo_reg    <= '0;
            port_reg[0]   <= '0;
            port_reg[1]   <= '0;
            early_err_reg <= ST_OK;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
            if (proc) begin
                offset_reg      <= offset_next;
                phase_reg       <= phase_next;
                net_start_reg   <= net_start_next;
                trans_start_reg <= trans_start_next;
                type_word_reg   <= type_word_next;
                ip_proto_reg    <= ip_proto_next;
                arp_hdr_reg     <= arp_hdr_next;
                src_hi_reg      <= src_hi_next;
                src_lo_reg      <= src_lo_next;
                dst_hi_reg      <= dst_hi_next;
                dst_lo_reg      <= dst_lo_next;
                port_reg        <= port_next;
                early_err_reg   <= early_err_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        if (load) begin
            m_data_reg <= result;
        end
    end

    `EIPHP_ASSERT_NOW(a_stall_only_on_full_output, aclk, aresetn, !s_axis_tready, in_valid_reg && in_last_reg && m_valid_reg)
    `EIPHP_ASSERT_NEXT(a_last_clears_frame, aclk, aresetn, load, m_valid_reg && phase_reg == PH_ETH && offset_reg == '0)
    `EIPHP_ASSERT_NEXT(a_offset_advances, aclk, aresetn, proc && !in_last_reg, offset_reg != '0)
    `EIPHP_ASSERT_NOW(a_error_zeroes_fields, aclk, aresetn, m_valid_reg && m_data_reg.parse_status != ST_OK, m_data_reg[RESULT_BITS-1:4] == '0)

endmodule

`default_nettype wire
